[sv/rc5_ir_frame_decoder_unit_macros.svh]
// Assertion macros shared by the RC5 infrared frame decoder modules.
`ifndef RC5_IR_FRAME_DECODER_UNIT_MACROS_SVH
`define RC5_IR_FRAME_DECODER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define RC5IR_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("rc5ir: same-cycle check failed");
`define RC5IR_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("rc5ir: next-cycle check failed");
`else
`define RC5IR_ASSERT_IMPL(label, clk, rst, pre, post)
`define RC5IR_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

[sv/rc5ir_pkg.sv]
// Types and constants shared by the RC5 infrared frame decoder modules.
package rc5ir_pkg;

   // Transaction commands.
   localparam logic CMD_EDGE = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Gap classes decided by the front end.
   localparam logic [1:0] GAP_SILENCE = 2'd0;
   localparam logic [1:0] GAP_SHORT   = 2'd1;
   localparam logic [1:0] GAP_LONG    = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 24;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_GAP_MAX = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SILENCE_MIN   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_FORGET   = 2'd2;

   // Register reset values.
   localparam logic [15:0] SHORT_GAP_MAX_RESET = 16'd1200;
   localparam logic [19:0] SILENCE_MIN_RESET   = 20'd10000;
   localparam logic [23:0] IDLE_FORGET_RESET   = 24'd1000000;

   localparam logic [31:0] TOGGLE_MASK = 32'h0000_0800;

   // Queue between front end and decoder.
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [15:0] short_gap_max_us;
      logic [19:0] silence_min_us;
      logic [23:0] idle_forget_us;
   } csr_type;

   typedef struct packed {
      logic        command;
      logic [31:0] edge_time_us;
      logic        pin_level;
      logic [1:0]  gap_class;
   } queue_entry_type;

endpackage

[sv/rc5ir_front.sv]
// Front end: accepts transactions, measures and classifies the edge gap.
module rc5ir_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_command,
   input  logic [31:0]               req_edge_time_us,
   input  logic                      req_pin_level,
   input  logic                      queue_full,
   input  rc5ir_pkg::csr_type        csr,
   output logic                      push,
   output rc5ir_pkg::queue_entry_type push_entry
);

   logic [31:0] last_edge_ff;
   logic [31:0] last_edge_in;
   logic [31:0] gap;
   logic [1:0]  gap_class;

   assign push = req_valid && !queue_full;
   assign gap  = req_edge_time_us - last_edge_ff;

   always_comb begin
      priority if (gap >= {12'd0, csr.silence_min_us}) begin
         gap_class = rc5ir_pkg::GAP_SILENCE;
      end else if (gap < {16'd0, csr.short_gap_max_us}) begin
         gap_class = rc5ir_pkg::GAP_SHORT;
      end else begin
         gap_class = rc5ir_pkg::GAP_LONG;
      end
   end

   always_comb begin
      last_edge_in = last_edge_ff;
      if (push && req_command == rc5ir_pkg::CMD_EDGE) begin
         last_edge_in = req_edge_time_us;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_edge_ff <= '0;
      end else begin
         last_edge_ff <= last_edge_in;
      end
   end

   always_comb begin
      push_entry.command      = req_command;
      push_entry.edge_time_us = req_edge_time_us;
      push_entry.pin_level    = req_pin_level;
      push_entry.gap_class    = gap_class;
   end

endmodule

[sv/rc5ir_queue.sv]
// Two-entry queue between the front end and the decoder.
`include "rc5_ir_frame_decoder_unit_macros.svh"
module rc5ir_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  rc5ir_pkg::queue_entry_type push_entry,
   input  logic                       pop,
   output logic                       head_valid,
   output rc5ir_pkg::queue_entry_type head_entry,
   output logic                       full
);

   localparam int unsigned PtrW = $clog2(rc5ir_pkg::QUEUE_DEPTH);
   localparam int unsigned CntW = $clog2(rc5ir_pkg::QUEUE_DEPTH + 1);
   localparam logic [CntW-1:0] CountFull = CntW'(rc5ir_pkg::QUEUE_DEPTH);
   localparam logic [PtrW-1:0] PtrLast   = PtrW'(rc5ir_pkg::QUEUE_DEPTH - 1);

   rc5ir_pkg::queue_entry_type entry_ff [rc5ir_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CountFull);
   assign head_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `RC5IR_ASSERT_IMPL(a_no_push_when_full, clock, reset, full, !push)
   `RC5IR_ASSERT_IMPL(a_no_pop_when_empty, clock, reset, !head_valid, !pop)
   `RC5IR_ASSERT_NEXT(a_fills_up, clock, reset, push && !pop && count_ff == CountFull - 1'b1, full)

endmodule

[sv/rc5ir_back.sv]
// Decoder back end: half-bit counting, frame assembly, mailbox and result register.
`include "rc5_ir_frame_decoder_unit_macros.svh"
module rc5ir_back #(
   parameter int unsigned FRAME_HALF_BITS = 27
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       head_valid,
   input  rc5ir_pkg::queue_entry_type head_entry,
   output logic                       pop,
   input  rc5ir_pkg::csr_type         csr,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_code_found,
   output logic [31:0]                rsp_key_code
);

   localparam logic [7:0] FrameEnd = 8'(FRAME_HALF_BITS);

   logic [7:0]  half_count_ff, half_count_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] last_code_ff, last_code_in;
   logic        last_valid_ff, last_valid_in;
   logic [31:0] last_time_ff, last_time_in;
   logic [31:0] mailbox_code_ff, mailbox_code_in;
   logic        mailbox_full_ff, mailbox_full_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_found_ff, rsp_found_in;
   logic [31:0] rsp_code_ff, rsp_code_in;

   logic [31:0] shifted;
   logic [31:0] shift_step;
   logic [7:0]  count_step;
   logic [8:0]  count_sum;
   logic [1:0]  add_amount;
   logic        frame_done;
   logic [31:0] frame;
   logic [31:0] since_last;
   logic [31:0] stripped;
   logic        do_edge;
   logic        do_read;

   assign pop     = head_valid && (head_entry.command == rc5ir_pkg::CMD_EDGE
                                   || !rsp_valid_ff || !rsp_stall);
   assign do_edge = pop && head_entry.command == rc5ir_pkg::CMD_EDGE;
   assign do_read = pop && head_entry.command == rc5ir_pkg::CMD_READ;

   assign shifted = {shift_ff[30:0], head_entry.pin_level};

   // Half-bit step; a data bit lands on each mid-bit edge.
   always_comb begin
      add_amount = 2'd0;
      shift_step = shift_ff;
      unique case (head_entry.gap_class)
         rc5ir_pkg::GAP_SHORT: begin
            add_amount = 2'd1;
            if (!half_count_ff[0]) shift_step = shifted;
         end
         rc5ir_pkg::GAP_LONG: begin
            add_amount = 2'd2;
            if (half_count_ff[0]) shift_step = shifted;
         end
         default: begin
            shift_step = '0;
         end
      endcase
      count_sum = {1'b0, half_count_ff} + {7'd0, add_amount};
      if (head_entry.gap_class == rc5ir_pkg::GAP_SILENCE) begin
         count_step = 8'd1;
      end else if (count_sum[8]) begin
         count_step = 8'hFF;
      end else begin
         count_step = count_sum[7:0];
      end
   end

   assign frame_done = (count_step == FrameEnd);
   assign frame      = frame_done ? shift_step : '0;
   assign since_last = head_entry.edge_time_us - last_time_ff;
   assign stripped   = frame & ~rc5ir_pkg::TOGGLE_MASK;

   always_comb begin
      half_count_in   = half_count_ff;
      shift_in        = shift_ff;
      last_code_in    = last_code_ff;
      last_valid_in   = last_valid_ff;
      last_time_in    = last_time_ff;
      mailbox_code_in = mailbox_code_ff;
      mailbox_full_in = mailbox_full_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_code_in     = rsp_code_ff;
      rsp_valid_in    = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (do_edge) begin
         half_count_in = frame_done ? 8'd0 : count_step;
         shift_in      = shift_step;
         if (frame != '0) begin
            last_time_in = head_entry.edge_time_us;
            if (!last_valid_ff || frame != last_code_ff) begin
               mailbox_code_in = stripped;
               mailbox_full_in = (stripped != '0);
               last_code_in    = frame;
               last_valid_in   = 1'b1;
            end
         end else if (since_last >= {8'd0, csr.idle_forget_us}) begin
            last_valid_in = 1'b0;
            last_code_in  = '0;
         end
      end
      if (do_read) begin
         rsp_valid_in    = 1'b1;
         rsp_found_in    = mailbox_full_ff;
         rsp_code_in     = mailbox_full_ff ? mailbox_code_ff : '0;
         mailbox_code_in = '0;
         mailbox_full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_count_ff   <= '0;
         shift_ff        <= '0;
         last_code_ff    <= '0;
         last_valid_ff   <= 1'b0;
         last_time_ff    <= '0;
         mailbox_code_ff <= '0;
         mailbox_full_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         half_count_ff   <= half_count_in;
         shift_ff        <= shift_in;
         last_code_ff    <= last_code_in;
         last_valid_ff   <= last_valid_in;
         last_time_ff    <= last_time_in;
         mailbox_code_ff <= mailbox_code_in;
         mailbox_full_ff <= mailbox_full_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_code_ff  <= rsp_code_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code_found = rsp_found_ff;
   assign rsp_key_code   = rsp_code_ff;

   `RC5IR_ASSERT_IMPL(a_empty_read_is_zero, clock, reset, rsp_valid_ff && !rsp_found_ff, rsp_code_ff == '0)
   `RC5IR_ASSERT_IMPL(a_full_mailbox_nonzero, clock, reset, mailbox_full_ff, mailbox_code_ff != '0)

endmodule

[sv/rc5_ir_frame_decoder_unit.sv]
// Top level of the RC5 infrared frame decoder.
//
// The block decodes a Manchester-coded RC5 infrared stream from edge transactions
// (command 0, with a microsecond timestamp and the inverted pin level) and answers
// read transactions (command 1) with one result that empties the one-entry mailbox.
// It takes one transaction per clock cycle for as long as the result side keeps up.
// An accepted transaction is classified in the front end in the same cycle (gap
// measurement against the previous edge), waits in a two-entry queue and is then carried
// out by the decoder. A read result passes through the queue register and the decoder's
// result register before it is offered on the rsp channel, and it is held in that output
// register until taken.
// A stalled result holds back the next read in the decoder, and everything queued
// behind that read. Edges ahead of it keep flowing, and the front end stops taking
// transactions only when the queue is full.
// Configuration registers are written by index through the csr port and should only
// be changed while no transaction is in flight.
module rc5_ir_frame_decoder_unit #(
   parameter int unsigned FRAME_HALF_BITS = 27
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_command,
   input  logic [31:0]                      req_edge_time_us,
   input  logic                             req_pin_level,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_code_found,
   output logic [31:0]                      rsp_key_code,
   input  logic                             csr_write_en,
   input  logic [rc5ir_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rc5ir_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   rc5ir_pkg::csr_type         csr_ff, csr_in;
   rc5ir_pkg::queue_entry_type push_entry;
   rc5ir_pkg::queue_entry_type head_entry;
   logic                       push;
   logic                       pop;
   logic                       head_valid;
   logic                       queue_full;

   // Configuration registers: each write keeps only the register's own width.
   always_comb begin
      csr_in = csr_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            rc5ir_pkg::CSR_SHORT_GAP_MAX: csr_in.short_gap_max_us = csr_wdata[15:0];
            rc5ir_pkg::CSR_SILENCE_MIN:   csr_in.silence_min_us   = csr_wdata[19:0];
            rc5ir_pkg::CSR_IDLE_FORGET:   csr_in.idle_forget_us   = csr_wdata[23:0];
            default: begin
               csr_in = csr_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.short_gap_max_us <= rc5ir_pkg::SHORT_GAP_MAX_RESET;
         csr_ff.silence_min_us   <= rc5ir_pkg::SILENCE_MIN_RESET;
         csr_ff.idle_forget_us   <= rc5ir_pkg::IDLE_FORGET_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // The front end stalls only on a full queue, which is a registered condition.
   assign req_stall = queue_full;

   rc5ir_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_command      (req_command),
      .req_edge_time_us (req_edge_time_us),
      .req_pin_level    (req_pin_level),
      .queue_full       (queue_full),
      .csr              (csr_ff),
      .push             (push),
      .push_entry       (push_entry)
   );

   rc5ir_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .full       (queue_full)
   );

   rc5ir_back #(
      .FRAME_HALF_BITS (FRAME_HALF_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_entry     (head_entry),
      .pop            (pop),
      .csr            (csr_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_found (rsp_code_found),
      .rsp_key_code   (rsp_key_code)
   );

endmodule

[tb/rc5_ir_frame_decoder_unit_checker.sv]
// Checker that predicts the read results of the RC5 infrared frame decoder and compares them.
`timescale 1ns / 100ps
module rc5_ir_frame_decoder_unit_checker #(
   parameter int unsigned FRAME_HALF_BITS = 27
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              req_command,
   input  logic [31:0]                       req_edge_time_us,
   input  logic                              req_pin_level,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic                              rsp_code_found,
   input  logic [31:0]                       rsp_key_code,
   input  logic                              csr_write_en,
   input  logic [rc5ir_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rc5ir_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                mismatch_count,
   output int                                pending_reads,
   output int                                codes_posted,
   output int                                reads_checked
);

   typedef struct packed {
      logic        found;
      logic [31:0] code;
   } mailbox_read_type;

   // Mailbox reads whose results have not yet come back, oldest first.
   mailbox_read_type awaited_reads[$];
   mailbox_read_type want;

   // Shadow copy of the registers.
   logic [15:0] short_gap_max;
   logic [19:0] silence_min;
   logic [23:0] idle_forget;

   // Shadow copy of the decoder state.
   logic [31:0] prev_edge_time;
   logic [7:0]  half_bits;
   logic [31:0] shift_reg;
   logic [31:0] held_code;
   logic        held_valid;
   logic [31:0] held_time;
   logic [31:0] mailbox_code;
   logic        mailbox_full;

   task automatic decode_edge(input logic [31:0] now, input logic pin);
      logic [31:0] gap;
      logic [31:0] frame;
      logic [8:0]  sum;
      gap = now - prev_edge_time;
      prev_edge_time = now;
      frame = '0;
      if (gap >= {12'd0, silence_min}) begin
         half_bits = 8'd1;
         shift_reg = '0;
      end else if (gap < {16'd0, short_gap_max}) begin
         if (!half_bits[0]) shift_reg = {shift_reg[30:0], pin};
         sum = {1'b0, half_bits} + 9'd1;
         half_bits = sum[8] ? 8'hFF : sum[7:0];
      end else begin
         if (half_bits[0]) shift_reg = {shift_reg[30:0], pin};
         sum = {1'b0, half_bits} + 9'd2;
         half_bits = sum[8] ? 8'hFF : sum[7:0];
      end
      if ({24'd0, half_bits} == FRAME_HALF_BITS) begin
         frame = shift_reg;
         half_bits = '0;
      end
      if (frame != '0) begin
         held_time = now;
         if (!held_valid || frame != held_code) begin
            mailbox_code = frame & ~rc5ir_pkg::TOGGLE_MASK;
            mailbox_full = (mailbox_code != '0);
            held_code = frame;
            held_valid = 1'b1;
            if (mailbox_full) codes_posted++;
         end
      end else if (now - held_time >= {8'd0, idle_forget}) begin
         // Long enough since the last frame: the same code counts as new again.
         held_valid = 1'b0;
         held_code = '0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         short_gap_max = rc5ir_pkg::SHORT_GAP_MAX_RESET;
         silence_min = rc5ir_pkg::SILENCE_MIN_RESET;
         idle_forget = rc5ir_pkg::IDLE_FORGET_RESET;
         prev_edge_time = '0;
         half_bits = '0;
         shift_reg = '0;
         held_code = '0;
         held_valid = 1'b0;
         held_time = '0;
         mailbox_code = '0;
         mailbox_full = 1'b0;
         awaited_reads.delete();
         mismatch_count = 0;
         codes_posted = 0;
         reads_checked = 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               rc5ir_pkg::CSR_SHORT_GAP_MAX: short_gap_max = csr_wdata[15:0];
               rc5ir_pkg::CSR_SILENCE_MIN:   silence_min = csr_wdata[19:0];
               rc5ir_pkg::CSR_IDLE_FORGET:   idle_forget = csr_wdata[23:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_reads.size() == 0) begin
               $display("%0t: unexpected result: expected none, got code_found=%0b key_code=%h",
                        $time, rsp_code_found, rsp_key_code);
               mismatch_count++;
            end else begin
               want = awaited_reads.pop_front();
               reads_checked++;
               if (rsp_code_found !== want.found) begin
                  $display("%0t: code_found mismatch: expected %0b, got %0b",
                           $time, want.found, rsp_code_found);
                  mismatch_count++;
               end
               if (rsp_key_code !== want.code) begin
                  $display("%0t: key_code mismatch: expected %h, got %h",
                           $time, want.code, rsp_key_code);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_command == rc5ir_pkg::CMD_READ) begin
               awaited_reads.push_back('{found: mailbox_full,
                                         code: mailbox_full ? mailbox_code : 32'd0});
               mailbox_code = '0;
               mailbox_full = 1'b0;
            end else begin
               decode_edge(req_edge_time_us, req_pin_level);
            end
         end
      end
      pending_reads = awaited_reads.size();
   end

endmodule

[tb/rc5_ir_frame_decoder_unit_tb.sv]
// Top of the RC5 infrared frame decoder testbench: stimulus, register settings and verdict.
`timescale 1ns / 100ps
module rc5_ir_frame_decoder_unit_tb;

   localparam int unsigned FRAME_HALF_BITS = 27;
   // A frame is the start bit followed by the code bits, two half-bits each.
   localparam int unsigned FRAME_BITS = (FRAME_HALF_BITS + 1) / 2;
   localparam int unsigned CODE_BITS = FRAME_BITS - 1;
   // Wait after the last result, so that every transaction still in the front end and
   // queue has run through and the block is certainly idle.
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned LIMIT_CYCLES = 200000;
   localparam int unsigned PHASES = 7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_command = rc5ir_pkg::CMD_EDGE;
   logic [31:0] req_edge_time_us = '0;
   logic req_pin_level = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_code_found;
   logic [31:0] rsp_key_code;
   logic csr_write_en = 1'b0;
   logic [rc5ir_pkg::CSR_INDEX_W-1:0] csr_index = rc5ir_pkg::CSR_SHORT_GAP_MAX;
   logic [rc5ir_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int mismatch_count;
   int pending_reads;
   int codes_posted;
   int reads_checked;

   // The register values currently in force, used to shape the pulse timing.
   int unsigned cfg_short = rc5ir_pkg::SHORT_GAP_MAX_RESET;
   int unsigned cfg_silence = rc5ir_pkg::SILENCE_MIN_RESET;
   int unsigned cfg_idle = rc5ir_pkg::IDLE_FORGET_RESET;

   logic [31:0] now_us = '0;
   logic [CODE_BITS-1:0] last_code_sent = '0;
   logic no_idle = 1'b0;
   int items_sent = 0;
   int edges_sent = 0;
   int reads_sent = 0;
   int cycle_count = 0;

   rc5_ir_frame_decoder_unit #(
      .FRAME_HALF_BITS (FRAME_HALF_BITS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_edge_time_us (req_edge_time_us),
      .req_pin_level    (req_pin_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_code_found   (rsp_code_found),
      .rsp_key_code     (rsp_key_code),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   rc5_ir_frame_decoder_unit_checker #(
      .FRAME_HALF_BITS (FRAME_HALF_BITS)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_edge_time_us (req_edge_time_us),
      .req_pin_level    (req_pin_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_code_found   (rsp_code_found),
      .rsp_key_code     (rsp_key_code),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .pending_reads    (pending_reads),
      .codes_posted     (codes_posted),
      .reads_checked    (reads_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The result side stalls in roughly a third of the cycles, except during the
   // stretch in which both sides run flat out.
   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99, 0) < 35);
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Run stopped after %0d cycles with %0d reads outstanding.",
                  cycle_count, pending_reads);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Offers one transaction and returns at the rising edge at which it was taken.
   // The stall is sampled at the falling edge, where it is settled, so the
   // handshake does not depend on event order at the rising edge.
   task automatic send_transaction(input logic cmd, input logic [31:0] stamp,
                                   input logic pin);
      logic taken;
      while (!no_idle && $urandom_range(99, 0) < 35) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_edge_time_us <= stamp;
      req_pin_level <= pin;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      items_sent++;
      if (cmd == rc5ir_pkg::CMD_READ) reads_sent++;
      else edges_sent++;
   endtask

   // An edge a given number of microseconds after the previous one.
   task automatic send_edge(input logic [31:0] gap, input logic pin);
      now_us = now_us + gap;
      send_transaction(rc5ir_pkg::CMD_EDGE, now_us, pin);
   endtask

   // A read carries random time and pin fields, which the block must ignore.
   task automatic send_read();
      send_transaction(rc5ir_pkg::CMD_READ, $urandom, 1'($urandom));
   endtask

   // Waits until every read result has come back and the block has gone quiet.
   task automatic await_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_reads != 0);
      @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all three registers in consecutive cycles; only called while idle.
   task automatic program_registers(input int unsigned short_max, input int unsigned silence,
                                    input int unsigned idle);
      csr_write_en <= 1'b1;
      csr_index <= rc5ir_pkg::CSR_SHORT_GAP_MAX;
      csr_wdata <= 24'(short_max);
      @(posedge clock);
      csr_index <= rc5ir_pkg::CSR_SILENCE_MIN;
      csr_wdata <= 24'(silence);
      @(posedge clock);
      csr_index <= rc5ir_pkg::CSR_IDLE_FORGET;
      csr_wdata <= 24'(idle);
      @(posedge clock);
      csr_write_en <= 1'b0;
      cfg_short = short_max;
      cfg_silence = silence;
      cfg_idle = idle;
   endtask

   // Well-formed frames need both a short and a long gap to exist below the silence.
   function automatic logic frames_possible();
      return cfg_short >= 1 && cfg_short < cfg_silence;
   endfunction

   // A gap that the decoder classes as one half-bit, or as two for anything longer.
   // The thresholds themselves are hit now and then.
   function automatic logic [31:0] gap_for(input int unsigned halves);
      int unsigned lo, hi;
      if (halves == 1) begin
         hi = cfg_short - 1;
         lo = hi / 2;
      end else begin
         lo = cfg_short;
         hi = cfg_silence - 1;
         if (hi - lo > 2 * lo) hi = 3 * lo;
      end
      case ($urandom_range(9, 0))
         0: return lo;
         1: return hi;
         default: return $urandom_range(hi, lo);
      endcase
   endfunction

   // The pause before a frame: sometimes well inside the forget time, sometimes
   // beyond it, and sometimes exactly the silence threshold.
   function automatic logic [31:0] pause_gap();
      int unsigned base;
      base = (cfg_idle > cfg_silence) ? cfg_idle : cfg_silence;
      case ($urandom_range(3, 0))
         0: return cfg_silence;
         1: return cfg_silence + $urandom_range(cfg_silence, 0);
         2: return base + $urandom_range(base, 0);
         default: return cfg_silence + $urandom_range(cfg_idle / 2, 0);
      endcase
   endfunction

   // Code content: plenty of repeats, to exercise the repeat suppression and the
   // forget time, and the corner codes (toggle bit alone, all zero, all ones).
   function automatic logic [CODE_BITS-1:0] pick_code();
      case ($urandom_range(19, 0))
         0, 1: return rc5ir_pkg::TOGGLE_MASK[CODE_BITS-1:0];
         2: return '0;
         3: return '1;
         4, 5, 6, 7, 8: return last_code_sent;
         9: return last_code_sent ^ rc5ir_pkg::TOGGLE_MASK[CODE_BITS-1:0];
         default: return CODE_BITS'($urandom);
      endcase
   endfunction

   // Sends one Manchester-coded frame as edge transactions. The half-bit levels
   // are built first; an edge falls wherever two neighbouring levels differ. Now
   // and then the frame is broken: cut off part-way or with one edge lost.
   task automatic send_frame(input logic [CODE_BITS-1:0] code);
      logic [2*FRAME_BITS-1:0] level;
      logic [FRAME_BITS-1:0] bits;
      int unsigned cut, skip, prev;
      bits = {1'b1, code};
      for (int i = 0; i < FRAME_BITS; i++) begin
         level[2*i] = ~bits[FRAME_BITS-1-i];
         level[2*i+1] = bits[FRAME_BITS-1-i];
      end
      cut = 2 * FRAME_BITS;
      skip = 0;
      case ($urandom_range(19, 0))
         0: cut = $urandom_range(FRAME_HALF_BITS - 1, 3);
         1: skip = $urandom_range(FRAME_HALF_BITS - 1, 3);
         default: ;
      endcase
      // The first edge ends the silence and falls mid-way through the start bit.
      send_edge(pause_gap(), level[1]);
      prev = 1;
      for (int unsigned k = 2; k < cut; k++) begin
         if (level[k] != level[k-1] && k != skip) begin
            if ($urandom_range(19, 0) == 0) send_read();
            send_edge(gap_for(k - prev), level[k]);
            prev = k;
         end
      end
      last_code_sent = code;
   endtask

   // Edges with arbitrary gaps, including jumps right across the timestamp wrap.
   task automatic send_noise(input int unsigned count);
      logic [31:0] gap;
      repeat (count) begin
         case ($urandom_range(3, 0))
            0: gap = $urandom;
            1: gap = $urandom_range(cfg_short + 1, 0);
            2: gap = $urandom_range(cfg_silence + 1, 0);
            default: gap = $urandom_range(cfg_silence, cfg_short);
         endcase
         if ($urandom_range(4, 0) == 0) send_read();
         send_edge(gap, 1'($urandom));
      end
   endtask

   // A long run of edges without silence that steps over the frame length, so
   // the half-bit counter climbs to saturation and the shift register overflows.
   task automatic send_runaway();
      send_edge(pause_gap(), 1'b1);
      send_edge(gap_for(1), 1'($urandom));
      repeat (FRAME_BITS - 1) send_edge(gap_for(2), 1'($urandom));
      repeat (150) send_edge(gap_for(($urandom_range(4, 0) == 0) ? 1 : 2), 1'($urandom));
      send_read();
   endtask

   task automatic run_episode();
      int unsigned pick;
      pick = $urandom_range(99, 0);
      if (frames_possible() && pick < 70) begin
         send_frame(pick_code());
         if ($urandom_range(9, 0) < 6) send_read();
      end else if (pick < 85) begin
         send_noise($urandom_range(12, 3));
      end else begin
         send_read();
      end
   endtask

   initial begin
      int phase_end;
      int unsigned short_max, silence, idle;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 0) begin
            // Directed opening at the reset register values. Reads on an empty
            // mailbox, one with random ignored fields and one with them all ones.
            send_read();
            send_transaction(rc5ir_pkg::CMD_READ, 32'hFFFF_FFFF, 1'b1);
            // A zero gap straight after reset, then the largest possible gap.
            send_transaction(rc5ir_pkg::CMD_EDGE, 32'h0000_0000, 1'b0);
            send_transaction(rc5ir_pkg::CMD_EDGE, 32'hFFFF_FFFF, 1'b1);
            now_us = 32'hFFFF_FFFF;
            // Gaps at the thresholds; the first one wraps the timestamp.
            send_edge(cfg_short - 1, 1'b0);
            send_edge(cfg_short, 1'b1);
            send_edge(cfg_silence - 1, 1'b0);
            send_edge(cfg_silence, 1'b1);
            send_read();
            // The sender holds off here until every result is back.
            await_drain();
            send_runaway();
         end else begin
            await_drain();
            case (phase)
               1: begin
                  short_max = 16'hFFFF;
                  silence = 20'hF_FFFF;
                  idle = 24'hFF_FFFF;
               end
               2: begin
                  // Smallest values with which frames still decode.
                  short_max = 1;
                  silence = 2;
                  idle = 1;
               end
               3: begin
                  short_max = 0;
                  silence = 0;
                  idle = 0;
               end
               4: begin
                  short_max = $urandom_range(4000, 300);
                  silence = $urandom_range(short_max * 12, short_max + 1);
                  idle = $urandom_range(24'hFF_FFFF, 1);
               end
               5: begin
                  short_max = $urandom_range(2000, 600);
                  silence = short_max * 4 + $urandom_range(short_max * 4, 0);
                  idle = $urandom_range(silence * 20, silence);
               end
               default: begin
                  short_max = 1200;
                  silence = 10000;
                  idle = 5000;
               end
            endcase
            program_registers(short_max, silence, idle);
         end
         // One setting runs with neither side idling.
         no_idle = (phase == 4);
         case (phase)
            0: phase_end = items_sent + 140;
            2: phase_end = items_sent + 120;
            3: phase_end = items_sent + 40;
            default: phase_end = items_sent + 150;
         endcase
         while (items_sent < phase_end) run_episode();
      end

      await_drain();
      $display("Sent %0d transactions (%0d edges, %0d reads); %0d results checked, %0d codes posted.",
               items_sent, edges_sent, reads_sent, reads_checked, codes_posted);
      $display("Covered %0d register settings, both extremes, and a burst to counter saturation.",
               PHASES);
      if (mismatch_count == 0 && pending_reads == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/rc5ir_pkg.sv
sv/rc5ir_front.sv
sv/rc5ir_queue.sv
sv/rc5ir_back.sv
sv/rc5_ir_frame_decoder_unit.sv
tb/rc5_ir_frame_decoder_unit_checker.sv
tb/rc5_ir_frame_decoder_unit_tb.sv
